// ===== hw/rtl/sdc_pkg.sv =====
// Shared types and constants for the single/double click detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sdc_pkg;

   localparam int unsigned WINDOW_WIDTH = 8;
   localparam int unsigned TICK_WIDTH   = 16;
   localparam int unsigned CSR_AW       = 3;
   localparam int unsigned CSR_DW       = 32;
   localparam int unsigned TDATA_WIDTH  = 8;

   localparam logic [WINDOW_WIDTH-1:0] CLICK_WINDOW_RESET = 8'd50;

   // Register index, taken from paddr[2] (word address).
   localparam logic REG_CLICK_WINDOW = 1'b0;

   typedef enum logic [1:0] {
      CLICK_NONE   = 2'd0,
      CLICK_SINGLE = 2'd1,
      CLICK_DOUBLE = 2'd2
   } click_kind_type;

   // Result side handshake toward the output buffer.
   typedef struct packed {
      logic           valid;
      click_kind_type kind;
   } click_result_type;

endpackage

// ===== hw/rtl/sdc_csr.sv =====
// Configuration register block: APB-style access to click_window.
// Depends on sdc_pkg.
`timescale 1ns / 1ps

module sdc_csr
   import sdc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_AW-1:0]       csr_paddr,
   input  logic [CSR_DW-1:0]       csr_pwdata,
   output logic [CSR_DW-1:0]       csr_prdata,
   output logic                    csr_pready,
   output logic [WINDOW_WIDTH-1:0] click_window
);

   logic [WINDOW_WIDTH-1:0] click_window_ff;
   logic [WINDOW_WIDTH-1:0] click_window_in;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      click_window_in = click_window_ff;
      if (wr_en && (csr_paddr[2] == REG_CLICK_WINDOW)) begin
         click_window_in = csr_pwdata[WINDOW_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         click_window_ff <= CLICK_WINDOW_RESET;
      end else begin
         click_window_ff <= click_window_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_CLICK_WINDOW: csr_prdata = {{(CSR_DW-WINDOW_WIDTH){1'b0}}, click_window_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign click_window = click_window_ff;

endmodule

// ===== hw/rtl/sdc_classifier.sv =====
// Click classifier: state registers and one-tick next-state/click logic.
// Depends on sdc_pkg.
`timescale 1ns / 1ps

module sdc_classifier
   import sdc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    key_level,
   input  logic [WINDOW_WIDTH-1:0] click_window,
   output click_kind_type          kind
);

   localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

   logic                  press_seen_ff,   press_seen_in;
   logic                  edge_handled_ff, edge_handled_in;
   logic [1:0]            press_count_ff,  press_count_in;
   logic [TICK_WIDTH-1:0] window_ticks_ff, window_ticks_in;
   logic [TICK_WIDTH-1:0] hold_ticks_ff,   hold_ticks_in;

   logic [TICK_WIDTH-1:0] window_ext;
   logic                  pressed;
   logic                  done;

   assign window_ext = {{(TICK_WIDTH-WINDOW_WIDTH){1'b0}}, click_window};
   assign pressed    = ~key_level;

   always_comb begin
      press_seen_in   = press_seen_ff;
      edge_handled_in = edge_handled_ff;
      press_count_in  = press_count_ff;
      window_ticks_in = window_ticks_ff;
      kind            = CLICK_NONE;
      done            = 1'b0;

      // hold counter saturates
      if (pressed) begin
         hold_ticks_in = (hold_ticks_ff == TICK_MAX) ? TICK_MAX : hold_ticks_ff + 1'b1;
         press_seen_in = 1'b1;
      end else begin
         hold_ticks_in = '0;
      end

      // count a new press once
      if (!edge_handled_ff) begin
         if (press_seen_in) begin
            press_count_in  = press_count_ff + 2'd1;
            edge_handled_in = 1'b1;
         end
         if (press_count_in == 2'd2) begin
            press_count_in  = 2'd0;
            window_ticks_in = '0;
            kind            = CLICK_DOUBLE;
            done            = 1'b1;
         end
      end

      if (!done) begin
         if (key_level) begin
            press_seen_in   = 1'b0;
            edge_handled_in = 1'b0;
         end
         if (press_count_in == 2'd1) begin
            window_ticks_in = (window_ticks_ff == TICK_MAX) ? TICK_MAX
                                                             : window_ticks_ff + 1'b1;
            if ((window_ticks_in > window_ext) && (hold_ticks_in < window_ext)) begin
               press_count_in  = 2'd0;
               window_ticks_in = '0;
               kind            = CLICK_SINGLE;
            end else if (hold_ticks_in > window_ext) begin
               // long hold: drop the pending click
               press_count_in  = 2'd0;
               window_ticks_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_seen_ff   <= 1'b0;
         edge_handled_ff <= 1'b0;
         press_count_ff  <= 2'd0;
         window_ticks_ff <= '0;
         hold_ticks_ff   <= '0;
      end else if (accept) begin
         press_seen_ff   <= press_seen_in;
         edge_handled_ff <= edge_handled_in;
         press_count_ff  <= press_count_in;
         window_ticks_ff <= window_ticks_in;
         hold_ticks_ff   <= hold_ticks_in;
      end
   end

   // Stored press count is 0 or 1; a second press resolves in the same tick.
   a_count_low: assert property (@(posedge clock) disable iff (reset)
      (press_count_ff == 2'd0) || (press_count_ff == 2'd1))
      else $error("press count left at %0d", press_count_ff);

   a_window_idle: assert property (@(posedge clock) disable iff (reset)
      (press_count_ff == 2'd0) |-> (window_ticks_ff == '0))
      else $error("window running with no pending press");

   a_click_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && (kind != CLICK_NONE)) |=> (press_count_ff == 2'd0))
      else $error("press count not cleared after click");

   a_release_clears_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && key_level) |=> (hold_ticks_ff == '0))
      else $error("hold count survived release");

endmodule

// ===== hw/rtl/sdc_out_buf.sv =====
// Two-entry result buffer (output register plus skid stage).
// Depends on sdc_pkg.
`timescale 1ns / 1ps

module sdc_out_buf
   import sdc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  click_result_type push,
   output logic             push_ready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output click_kind_type   rsp_kind
);

   logic           main_valid_ff, main_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   click_kind_type main_kind_ff,  main_kind_in;
   click_kind_type skid_kind_ff,  skid_kind_in;
   logic           pop;

   assign push_ready = ~skid_valid_ff;
   assign pop        = main_valid_ff & rsp_tready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_kind_in  = main_kind_ff;
      skid_kind_in  = skid_kind_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_kind_in  = skid_kind_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push.valid) begin
         if (!main_valid_ff || pop) begin
            main_kind_in  = push.kind;
            main_valid_in = 1'b1;
         end else begin
            skid_kind_in  = push.kind;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_kind_ff <= main_kind_in;
      skid_kind_ff <= skid_kind_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_kind   = main_kind_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry without output entry");

   a_skid_drains_first: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (main_kind_ff == $past(skid_kind_ff)))
      else $error("skid entry lost or reordered");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push.valid)
      else $error("transfer pushed into full buffer");

endmodule

// ===== hw/rtl/single_double_click_detector_unit.sv =====
// Single/double click detector, top level. Each input transfer's result
// is registered in the result buffer, shown on rsp_tvalid. Throughput: one
// item per cycle; req_tready drops only while both result slots are full.
// Reset (synchronous, active high): click_window returns to 50, all click
// state and result buffers clear. Depends on sdc_pkg and its submodules.
`timescale 1ns / 1ps

module single_double_click_detector_unit
   import sdc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TDATA_WIDTH-1:0] req_tdata,   // [0] key_level, [7:1] zero
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TDATA_WIDTH-1:0] rsp_tdata,   // [1:0] click_kind, [7:2] zero
   // configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_AW-1:0]      csr_paddr,
   input  logic [CSR_DW-1:0]      csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   logic [WINDOW_WIDTH-1:0] click_window;
   logic                    accept;
   click_kind_type          kind;
   click_kind_type          rsp_kind;
   click_result_type        result;

   // One register, word address 0 (paddr[2] selects the word).
   sdc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .click_window (click_window)
   );

   // State advances on the transfer; the click for that tick goes straight
   // into the result buffer in the same edge.
   assign accept = req_tvalid & req_tready;

   sdc_classifier u_classifier (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .key_level    (req_tdata[0]),
      .click_window (click_window),
      .kind         (kind)
   );

   assign result.valid = accept;
   assign result.kind  = kind;

   // Output register plus skid slot: input keeps flowing while one result
   // waits on a stalled consumer.
   sdc_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (result),
      .push_ready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_kind)
   );

   assign rsp_tdata = {{(TDATA_WIDTH-2){1'b0}}, rsp_kind};

endmodule
